/* design/rle_pair_token_decoder_top_macros.svh */
// Assertion macros for the run-length pair decoder.
// Used by the queue and the expander; expects clk and arst_n in scope.
`ifndef RLE_PAIR_TOKEN_DECODER_TOP_MACROS_SVH
`define RLE_PAIR_TOKEN_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RPD_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RPD_ASSERT(label, prop, msg)
`define RPD_NEVER(label, cond, msg)
`endif
`endif

/* design/rpd_pkg.sv */
// Shared types and constants of the run-length pair decoder.
// No dependencies; used by every other design file of the block but the macro header.
`default_nettype none
package rpd_pkg;
	localparam int BYTE_W     = 8;
	localparam int PACK_BYTES = 8;
	localparam int CNT_W      = 4;
	localparam int LEN_W      = 9;
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W    = $clog2(QUEUE_DEPTH);

	localparam logic [BYTE_W-1:0] CODE_END  = 8'h00;
	localparam logic [BYTE_W-1:0] CODE_PAIR = 8'h80;
	localparam logic [BYTE_W-1:0] RUN_MASK  = 8'h7F;

	typedef enum logic [1:0] {
		CMD_FILL,
		CMD_PAIR,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [BYTE_W-1:0]       val_a;
		logic [BYTE_W-1:0]       val_b;
		logic [LEN_W-1:0]        len;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage
`default_nettype wire

/* design/rpd_if.sv */
// Valid/ready channel interfaces of the decoder: packed bytes in, words out.
// Depends on rpd_pkg for field widths.
`default_nettype none
interface rpd_in_if;
	logic                      valid;
	logic                      ready;
	logic [rpd_pkg::BYTE_W-1:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface rpd_out_if;
	logic                       valid;
	logic                       ready;
	logic [rpd_pkg::BYTE_W-1:0] out_byte0;
	logic [rpd_pkg::BYTE_W-1:0] out_byte1;
	logic [rpd_pkg::BYTE_W-1:0] out_byte2;
	logic [rpd_pkg::BYTE_W-1:0] out_byte3;
	logic [rpd_pkg::BYTE_W-1:0] out_byte4;
	logic [rpd_pkg::BYTE_W-1:0] out_byte5;
	logic [rpd_pkg::BYTE_W-1:0] out_byte6;
	logic [rpd_pkg::BYTE_W-1:0] out_byte7;
	logic [rpd_pkg::CNT_W-1:0]  byte_count;
	logic                       run_done;
	logic                       end_marker;
	modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
		output out_byte3, output out_byte4, output out_byte5, output out_byte6,
		output out_byte7, output byte_count, output run_done, output end_marker,
		input ready);
	modport sink (input valid, input out_byte0, input out_byte1, input out_byte2,
		input out_byte3, input out_byte4, input out_byte5, input out_byte6,
		input out_byte7, input byte_count, input run_done, input end_marker,
		output ready);
endinterface
`default_nettype wire

/* design/rpd_front.sv */
// Parser: accepts packed bytes and turns tokens into expansion commands.
// Depends on rpd_pkg and rpd_in_if.
`default_nettype none
module rpd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	rpd_in_if.sink                stream,
	input  wire rpd_pkg::q_stat_t q_stat,
	output logic                  push,
	output rpd_pkg::cmd_t         push_cmd
);
	import rpd_pkg::*;

	typedef enum logic [2:0] {
		PH_CODE,
		PH_LIT,
		PH_RUNVAL,
		PH_PAIRCNT,
		PH_PAIRA,
		PH_PAIRB
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] rem_q, rem_d;
	logic [BYTE_W-1:0] first_q, first_d;
	logic              accept;
	logic              want_push;
	logic [BYTE_W-1:0] b;

	assign stream.ready = !q_stat.full;
	assign accept = stream.valid && stream.ready;
	assign b = stream.in_byte;
	assign push = accept && want_push;

	always_comb begin
		phase_d   = phase_q;
		rem_d     = rem_q;
		first_d   = first_q;
		want_push = 1'b0;
		push_cmd  = '{kind: CMD_FILL, val_a: b, val_b: '0, len: LEN_W'(1)};
		unique case (phase_q)
			PH_LIT: begin
				want_push = 1'b1;
				rem_d = rem_q - 8'd1;
				if (rem_d == '0) begin
					phase_d = PH_CODE;
				end
			end
			PH_RUNVAL: begin
				want_push = 1'b1;
				push_cmd.len = LEN_W'(rem_q);
				phase_d = PH_CODE;
			end
			PH_PAIRCNT: begin
				rem_d = b;
				phase_d = PH_PAIRA;
			end
			PH_PAIRA: begin
				first_d = b;
				phase_d = PH_PAIRB;
			end
			PH_PAIRB: begin
				// A pair count of zero consumes the pair and yields nothing.
				want_push = (rem_q != '0);
				push_cmd = '{kind: CMD_PAIR, val_a: first_q, val_b: b,
					len: {rem_q, 1'b0}};
				phase_d = PH_CODE;
			end
			default: begin
				phase_d = PH_CODE;
				if (b == CODE_END) begin
					want_push = 1'b1;
					push_cmd = '{kind: CMD_END, val_a: '0, val_b: '0, len: '0};
				end else if (b == CODE_PAIR) begin
					phase_d = PH_PAIRCNT;
				end else if (b[BYTE_W-1]) begin
					rem_d = b & RUN_MASK;
					phase_d = PH_RUNVAL;
				end else begin
					rem_d = b;
					phase_d = PH_LIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			rem_q   <= '0;
			first_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			first_q <= first_d;
		end
	end
endmodule
`default_nettype wire

/* design/rpd_queue.sv */
// Two-entry command queue between the parser and the expander.
// Depends on rpd_pkg and the assertion macro header.
`default_nettype none
`include "rle_pair_token_decoder_top_macros.svh"
module rpd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rpd_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output rpd_pkg::cmd_t      head,
	output rpd_pkg::q_stat_t   q_stat
);
	import rpd_pkg::*;

	cmd_t               slot_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   fill_q;

	assign q_stat.full  = (fill_q == (Q_PTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	`RPD_NEVER(a_no_overflow, push && q_stat.full && !pop, "command queue overflow")
	`RPD_NEVER(a_no_underflow, pop && q_stat.empty, "pop from empty command queue")
endmodule
`default_nettype wire

/* design/rpd_back.sv */
// Expander: carries out queued commands, one output word per cycle unless the output stalls.
// Depends on rpd_pkg, rpd_out_if and the assertion macro header.
`default_nettype none
`include "rle_pair_token_decoder_top_macros.svh"
module rpd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rpd_pkg::cmd_t    head,
	input  wire rpd_pkg::q_stat_t q_stat,
	output logic                  pop,
	rpd_out_if.source             words
);
	import rpd_pkg::*;

	cmd_t              cmd_q;
	logic [LEN_W-1:0]  left_q;
	logic              busy_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q [PACK_BYTES];
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic              end_q;

	logic              slot_free;
	logic              emit;
	logic              last;
	logic [CNT_W-1:0]  cnt;

	assign slot_free = !out_valid_q || words.ready;
	assign emit = busy_q && slot_free;
	assign last = (cmd_q.kind == CMD_END) || (left_q <= LEN_W'(PACK_BYTES));
	assign cnt = (left_q >= LEN_W'(PACK_BYTES)) ? CNT_W'(PACK_BYTES) : CNT_W'(left_q);
	assign pop = !q_stat.empty && (!busy_q || (emit && last));

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= head;
			left_q <= head.len;
		end else if (emit) begin
			left_q <= left_q - LEN_W'(PACK_BYTES);
		end
		if (emit) begin
			// Words start at even offsets, so odd slots carry the second pair byte.
			for (int j = 0; j < PACK_BYTES; j++) begin
				if (cmd_q.kind != CMD_END && CNT_W'(j) < cnt) begin
					byte_q[j] <= (cmd_q.kind == CMD_PAIR && j[0]) ? cmd_q.val_b : cmd_q.val_a;
				end else begin
					byte_q[j] <= '0;
				end
			end
			count_q <= (cmd_q.kind == CMD_END) ? '0 : cnt;
			done_q  <= last;
			end_q   <= (cmd_q.kind == CMD_END);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (slot_free) begin
				out_valid_q <= emit;
			end
		end
	end

	assign words.valid      = out_valid_q;
	assign words.out_byte0  = byte_q[0];
	assign words.out_byte1  = byte_q[1];
	assign words.out_byte2  = byte_q[2];
	assign words.out_byte3  = byte_q[3];
	assign words.out_byte4  = byte_q[4];
	assign words.out_byte5  = byte_q[5];
	assign words.out_byte6  = byte_q[6];
	assign words.out_byte7  = byte_q[7];
	assign words.byte_count = count_q;
	assign words.run_done   = done_q;
	assign words.end_marker = end_q;

	`RPD_ASSERT(a_busy_left, (busy_q && cmd_q.kind != CMD_END) |-> (left_q != '0), "active run with no bytes left")
	`RPD_ASSERT(a_word_count, out_valid_q |-> ((count_q != '0) || end_q), "empty word without end marker")
endmodule
`default_nettype wire

/* design/rle_pair_token_decoder_top.sv */
// Path: a command passes from the parser through a queue slot and the expander command register to the output word.
// Throughput: one packed byte per cycle while the two-entry command queue has room;
// a run of n bytes leaves the expander as ceil(n/8) words, one word per cycle unless the output stalls.
// Reset: arst_n clears parser phase, counters, queue pointers and output valid at once.
`default_nettype none
module rle_pair_token_decoder_top (
	input  wire logic clk,
	input  wire logic arst_n,
	rpd_in_if.sink    stream,
	rpd_out_if.source words
);
	import rpd_pkg::*;

	// The parser classifies each byte of the stream; each literal byte and each run token
	// become a single command, a pair token one command unless its count is zero, the end code
	// an end command, and other code bytes or pair operands simply update the parse state.
	logic    push;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;
	logic    pop;

	rpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// The queue lets the parser keep taking requests while a long run expands.
	rpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// The expander packs eight bytes per word into an output register, which
	// holds a stalled request while the next command is already loaded.
	rpd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.words  (words)
	);
endmodule
`default_nettype wire
